/* sv/mdms_pkg.sv */
// Shared types and constants for the motor drive mode supervisor.
// Holds the mode encoding, the key codes, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package mdms_pkg;

	typedef enum logic [1:0] {
		MODE_PRE  = 2'd0,
		MODE_OP   = 2'd1,
		MODE_STOP = 2'd2
	} mode_t;

	// Command characters (ASCII).
	localparam logic [7:0] KEY_OP      = 8'h6F; // 'o'
	localparam logic [7:0] KEY_PRE     = 8'h70; // 'p'
	localparam logic [7:0] KEY_REINIT  = 8'h72; // 'r'
	localparam logic [7:0] KEY_CLEAR   = 8'h63; // 'c'
	localparam logic [7:0] KEY_KP_UP   = 8'h37; // '7'
	localparam logic [7:0] KEY_KP_DOWN = 8'h31; // '1'
	localparam logic [7:0] KEY_TI_UP   = 8'h39; // '9'
	localparam logic [7:0] KEY_TI_DOWN = 8'h33; // '3'
	localparam logic [7:0] KEY_PI      = 8'h69; // 'i'

	localparam logic [1:0] CFG_FAULT_LIMIT = 2'd0;
	localparam logic [1:0] CFG_FAULT_DECAY = 2'd1;
	localparam logic [1:0] CFG_KP_START    = 2'd2;
	localparam logic [1:0] CFG_TI_START    = 2'd3;

	localparam logic [7:0]  FAULT_LIMIT_RST = 8'd50;
	localparam logic [7:0]  FAULT_DECAY_RST = 8'd10;
	localparam logic [15:0] KP_START_RST    = 16'd100;
	localparam logic [15:0] TI_START_RST    = 16'd100;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 48;

	typedef struct packed {
		logic [7:0] key_code;
		logic       fault_pin_low;
		logic       timeout_pulse;
	} item_t;

	typedef struct packed {
		logic       we;
		logic [1:0] index;
		logic [15:0] data;
	} cfg_wr_t;

	typedef struct packed {
		mode_t       mode;
		logic        fault;
		logic        ret_pre;
		logic [8:0]  cnt;
		logic [15:0] kp;
		logic [15:0] ti;
		logic        pi;
	} sup_state_t;

endpackage

/* sv/mdms_in_reg.sv */
// Input register stage of the mode supervisor.
// Captures one tick request from the slave stream; uses mdms_pkg.
`timescale 1ns / 1ps

module mdms_in_reg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mdms_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                out_ok,
	output logic                                valid_s1,
	output mdms_pkg::item_t                     item_s1
);
	import mdms_pkg::*;

	assign s_tready = !valid_s1 || out_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.key_code      <= s_tdata[7:0];
			item_s1.fault_pin_low <= s_tdata[8];
			item_s1.timeout_pulse <= s_tdata[9];
		end
	end

endmodule

/* sv/mdms_core.sv */
// Mode state machine, fault counter, tuning counts and configuration registers.
// Computes the state after one tick and commits it on each step; uses mdms_pkg.
`timescale 1ns / 1ps

module mdms_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mdms_pkg::cfg_wr_t     cfg,
	input  logic                  step,
	input  mdms_pkg::item_t       item_s1,
	output mdms_pkg::sup_state_t  nxt
);
	import mdms_pkg::*;

	sup_state_t  st_q;
	logic [7:0]  limit_q;
	logic [7:0]  decay_q;
	logic        fault_t;
	logic [8:0]  cnt_t;
	logic [15:0] cfg_nz;

	assign cfg_nz = (cfg.data == 16'd0) ? 16'd1 : cfg.data;

	always_comb begin
		nxt     = st_q;
		fault_t = st_q.fault;
		cnt_t   = st_q.cnt;
		unique case (st_q.mode)
			MODE_PRE: begin
				if (item_s1.key_code == KEY_OP) begin
					nxt.mode    = MODE_OP;
					nxt.fault   = 1'b0;
					nxt.ret_pre = 1'b0;
				end else if (item_s1.key_code == KEY_REINIT) begin
					nxt.fault   = 1'b0;
					nxt.ret_pre = 1'b1;
				end else if (st_q.fault) begin
					nxt.ret_pre = 1'b1;
					nxt.mode    = MODE_STOP;
				end else begin
					case (item_s1.key_code)
						KEY_KP_UP:   if (st_q.kp != 16'hFFFF) nxt.kp = st_q.kp + 16'd1;
						KEY_KP_DOWN: if (st_q.kp > 16'd1) nxt.kp = st_q.kp - 16'd1;
						KEY_TI_UP:   if (st_q.ti != 16'hFFFF) nxt.ti = st_q.ti + 16'd1;
						KEY_TI_DOWN: if (st_q.ti > 16'd1) nxt.ti = st_q.ti - 16'd1;
						KEY_PI:      nxt.pi = !st_q.pi;
						default:     nxt.pi = st_q.pi;
					endcase
				end
			end
			MODE_OP: begin
				fault_t = st_q.fault | item_s1.timeout_pulse;
				// Leaky counter: rises on a low pin, decays towards zero otherwise.
				if (item_s1.fault_pin_low) begin
					cnt_t = (st_q.cnt != 9'h1FF) ? st_q.cnt + 9'd1 : st_q.cnt;
				end else begin
					cnt_t = (st_q.cnt > {1'b0, decay_q}) ? st_q.cnt - {1'b0, decay_q} : 9'd0;
				end
				if (cnt_t > {1'b0, limit_q}) begin
					cnt_t   = 9'd0;
					fault_t = 1'b1;
				end
				nxt.cnt   = cnt_t;
				nxt.fault = fault_t;
				if (item_s1.key_code == KEY_REINIT) begin
					nxt.mode    = MODE_PRE;
					nxt.fault   = 1'b0;
					nxt.ret_pre = 1'b1;
				end else if (fault_t) begin
					nxt.ret_pre = 1'b0;
					nxt.mode    = MODE_STOP;
				end else if (item_s1.key_code == KEY_PRE) begin
					nxt.mode    = MODE_PRE;
					nxt.ret_pre = 1'b1;
				end
			end
			default: begin
				if (item_s1.key_code == KEY_CLEAR) begin
					nxt.fault = 1'b0;
					if (st_q.ret_pre) begin
						nxt.mode = MODE_PRE;
					end else begin
						nxt.mode    = MODE_OP;
						nxt.ret_pre = 1'b0;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode    <= MODE_PRE;
			st_q.fault   <= 1'b0;
			st_q.ret_pre <= 1'b1;
			st_q.cnt     <= 9'd0;
			st_q.kp      <= KP_START_RST;
			st_q.ti      <= TI_START_RST;
			st_q.pi      <= 1'b0;
			limit_q      <= FAULT_LIMIT_RST;
			decay_q      <= FAULT_DECAY_RST;
		end else if (cfg.we) begin
			// Writing a start value loads the live count straight away.
			unique case (cfg.index)
				CFG_FAULT_LIMIT: limit_q <= cfg.data[7:0];
				CFG_FAULT_DECAY: decay_q <= cfg.data[7:0];
				CFG_KP_START:    st_q.kp <= cfg_nz;
				CFG_TI_START:    st_q.ti <= cfg_nz;
				default:         limit_q <= limit_q;
			endcase
		end else if (step) begin
			st_q <= nxt;
		end
	end

endmodule

/* sv/mdms_out_reg.sv */
// Result register of the mode supervisor, facing the master stream.
// Packs the state after a tick into tdata; uses mdms_pkg.
`timescale 1ns / 1ps

module mdms_out_reg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  mdms_pkg::sup_state_t              nxt,
	output logic                              out_ok,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mdms_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import mdms_pkg::*;

	assign out_ok = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_ok) begin
			m_tvalid <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_tdata <= {2'b00, (nxt.mode == MODE_OP), nxt.pi, nxt.ti, nxt.kp,
				nxt.cnt, nxt.fault, nxt.mode};
		end
	end

endmodule

/* sv/motor_drive_mode_supervisor_top.sv */
// Top level of the motor drive mode supervisor.
// Instantiates mdms_in_reg, mdms_core and mdms_out_reg; uses mdms_pkg.
`timescale 1ns / 1ps

// Each tick request on the slave stream yields exactly one result on the master
// stream. The block takes one request per clock cycle sustained while the master
// side takes each result, a rate set by the loop through the mode and counter
// registers in mdms_core. A request is first captured in the input register, and
// on a step its result is then loaded into the result register. While a result
// waits at the output, one further request can still enter the input register;
// after that the slave side stalls until the result is taken. Configuration writes
// are taken at any edge with cfg_we high and must only be made while the block is
// idle; a write of kp_start or ti_start also loads the live Kp or Ti count, and a
// value of zero is stored as one.
module motor_drive_mode_supervisor_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [15:0]                       cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// key_code[7:0], fault_pin_low[8], timeout_pulse[9], zero[15:10]
	input  logic [mdms_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// mode_code[1:0], fault_active[2], fault_level[11:3], gain_kp[27:12],
	// time_ti[43:28], integral_on[44], drive_enable[45], zero[47:46]
	output logic [mdms_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import mdms_pkg::*;

	cfg_wr_t    cfg;
	item_t      item_s1;
	sup_state_t nxt;
	logic       valid_s1;
	logic       out_ok;
	logic       step;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;
	assign step      = valid_s1 && out_ok;

	mdms_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.out_ok   (out_ok),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mdms_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (step),
		.item_s1 (item_s1),
		.nxt     (nxt)
	);

	mdms_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.nxt      (nxt),
		.out_ok   (out_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// A free result slot always lets a new request in.
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_ok |-> s_tready)
		else $error("input stalled while the result register was free");

	// A request held in the input stage reaches the result register on a step.
	a_step_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> m_tvalid)
		else $error("stepped request did not produce a result");

	// The fault counter is cleared once it passes the limit, so it stays small.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[11:3] <= 9'd256))
		else $error("fault level out of range");

	// Operational mode is never reported together with a set fault.
	a_enable_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[45]) |-> !m_tdata[2])
		else $error("drive enabled while a fault is flagged");

endmodule
